// ===== rtl/lrl_pkg.sv =====
// Shared types, codes and helpers for the per-source login rate limiter.
package lrl_pkg;

  localparam int unsigned SourceEntriesDefault = 16;

  localparam logic [7:0]  FailureLimitReset = 8'd5;
  localparam logic [31:0] WindowTicksReset  = 32'd900;
  localparam logic [31:0] LockoutTicksReset = 32'd900;
  localparam logic [4:0]  SourceLimitReset  = 5'd16;

  typedef enum logic [2:0] {
    OP_RESERVE     = 3'd0,
    OP_QUERY       = 3'd1,
    OP_FAIL        = 3'd2,
    OP_SUCCESS     = 3'd3,
    OP_FINISH_OK   = 3'd4,
    OP_FINISH_FAIL = 3'd5,
    OP_FINISH_NEUT = 3'd6,
    OP_COUNT       = 3'd7
  } op_e;

  typedef enum logic [2:0] {
    ST_DONE      = 3'd0,
    ST_LOCKED    = 3'd1,
    ST_LIMIT     = 3'd2,
    ST_SATURATED = 3'd3,
    ST_NO_ENTRY  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CFG_FAILURE_LIMIT = 2'd0,
    CFG_WINDOW_TICKS  = 2'd1,
    CFG_LOCKOUT_TICKS = 2'd2,
    CFG_SOURCE_LIMIT  = 2'd3
  } cfg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DROP,
    S_SCAN,
    S_EXEC,
    S_OUT
  } state_e;

  typedef struct packed {
    logic        unknown;
    logic [63:0] key_high;
    logic [63:0] key_low;
    logic [7:0]  fail;
    logic [7:0]  resv;
    logic [31:0] wstart;
    logic [31:0] blocked;
    logic [31:0] seen_at;
  } data_t;

  typedef struct packed {
    logic        hit;
    logic        free_found;
    logic [7:0]  fail;
    logic [7:0]  resv;
    logic [31:0] wstart;
    logic [31:0] blocked;
  } hit_t;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic logic elapsed_ge(input logic [31:0] now, input logic [31:0] since,
                                      input logic [32:0] span);
    logic [31:0] d;
    d = now - since;
    return (now >= since) && ({1'b0, d} >= span);
  endfunction

endpackage

// ===== rtl/lrl_cell.sv =====
// One table entry of the source table, with its stage of the lookup chain.
module lrl_cell import lrl_pkg::*; #(
  parameter int unsigned IDX_W    = 4,
  parameter int unsigned CNT_W    = 5,
  parameter int unsigned CELL_IDX = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             drop_i,
  input  logic [31:0]      now_i,
  input  logic [32:0]      retention_i,
  input  logic             unknown_i,
  input  logic [63:0]      key_high_i,
  input  logic [63:0]      key_low_i,
  input  logic             step_i,
  input  hit_t             prev_hit_i,
  input  logic [IDX_W-1:0] prev_hit_idx_i,
  input  logic [IDX_W-1:0] prev_free_idx_i,
  input  logic [CNT_W-1:0] prev_count_i,
  input  logic             wr_en_i,
  input  logic             wr_valid_i,
  input  data_t            wr_data_i,
  output hit_t             hit_o,
  output logic [IDX_W-1:0] hit_idx_o,
  output logic [IDX_W-1:0] free_idx_o,
  output logic [CNT_W-1:0] count_o
);

  logic             valid_q;
  data_t            data_q;
  hit_t             hit_q, hit_d;
  logic [IDX_W-1:0] hit_idx_q, hit_idx_d, free_idx_q, free_idx_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             match, stale;

  assign match = valid_q && (data_q.unknown == unknown_i) &&
                 (unknown_i || (data_q.key_high == key_high_i && data_q.key_low == key_low_i));
  assign stale = valid_q && (data_q.resv == 8'd0) && (data_q.blocked <= now_i) &&
                 elapsed_ge(now_i, data_q.seen_at, retention_i);

  always_comb begin
    hit_d      = prev_hit_i;
    hit_idx_d  = prev_hit_idx_i;
    free_idx_d = prev_free_idx_i;
    count_d    = prev_count_i + CNT_W'(valid_q);
    if (!prev_hit_i.hit && match) begin
      hit_d.hit    = 1'b1;
      hit_d.fail   = data_q.fail;
      hit_d.resv   = data_q.resv;
      hit_d.wstart = data_q.wstart;
      hit_d.blocked = data_q.blocked;
      hit_idx_d    = IDX_W'(CELL_IDX);
    end
    if (!prev_hit_i.free_found && !valid_q) begin
      hit_d.free_found = 1'b1;
      free_idx_d       = IDX_W'(CELL_IDX);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (wr_en_i) begin
      valid_q <= wr_valid_i;
    end else if (drop_i && stale) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      data_q <= wr_data_i;
    end
    if (step_i) begin
      hit_q      <= hit_d;
      hit_idx_q  <= hit_idx_d;
      free_idx_q <= free_idx_d;
      count_q    <= count_d;
    end
  end

  assign hit_o      = hit_q;
  assign hit_idx_o  = hit_idx_q;
  assign free_idx_o = free_idx_q;
  assign count_o    = count_q;

endmodule

// ===== rtl/lrl_exec.sv =====
// Per-item decision and entry update from the lookup result.
module lrl_exec import lrl_pkg::*; #(
  parameter int unsigned SOURCE_ENTRIES = SourceEntriesDefault,
  parameter int unsigned IDX_W          = 4,
  parameter int unsigned CNT_W          = 5
) (
  input  op_e              op_i,
  input  logic             unknown_i,
  input  logic [63:0]      key_high_i,
  input  logic [63:0]      key_low_i,
  input  logic [31:0]      now_i,
  input  logic [7:0]       failure_limit_i,
  input  logic [31:0]      window_ticks_i,
  input  logic [31:0]      lockout_ticks_i,
  input  logic [4:0]       source_limit_i,
  input  logic [31:0]      sat_until_i,
  input  hit_t             hit_i,
  input  logic [IDX_W-1:0] hit_idx_i,
  input  logic [IDX_W-1:0] free_idx_i,
  input  logic [CNT_W-1:0] count_i,
  output logic             wr_en_o,
  output logic [IDX_W-1:0] wr_idx_o,
  output logic             wr_valid_o,
  output data_t            wr_data_o,
  output logic             sat_we_o,
  output logic [31:0]      sat_d_o,
  output logic             granted_o,
  output status_e          status_o,
  output logic [CNT_W-1:0] count_o
);

  logic [31:0] lock_end, lim32;
  logic        full, create, sat_req;
  logic [7:0]  f, r;
  logic [31:0] ws, bu;
  logic [32:0] span;

  always_comb begin
    lock_end = sat_add(now_i, lockout_ticks_i);
    span     = {1'b0, window_ticks_i};
    lim32    = (32'(source_limit_i) < 32'(SOURCE_ENTRIES)) ? 32'(source_limit_i)
                                                         : 32'(SOURCE_ENTRIES);
    full     = 32'(count_i) >= lim32;
    create   = 1'b0;
    sat_req  = 1'b0;
    wr_en_o  = 1'b0;
    wr_valid_o = 1'b1;
    granted_o = 1'b0;
    status_o  = ST_DONE;
    f  = hit_i.hit ? hit_i.fail    : 8'd0;
    r  = hit_i.hit ? hit_i.resv    : 8'd0;
    ws = hit_i.hit ? hit_i.wstart  : now_i;
    bu = hit_i.hit ? hit_i.blocked : 32'd0;
    wr_idx_o = hit_i.hit ? hit_idx_i : free_idx_i;

    case (op_i)
      OP_RESERVE: begin
        if (!hit_i.hit) begin
          if (sat_until_i > now_i || full) begin
            sat_req  = 1'b1;
            status_o = ST_SATURATED;
          end else if (!hit_i.free_found) begin
            status_o = ST_SATURATED;
          end else begin
            create = 1'b1;
          end
        end
        if (hit_i.hit || create) begin
          wr_en_o = 1'b1;
          if (bu > now_i) begin
            status_o = ST_LOCKED;
          end else begin
            if (elapsed_ge(now_i, ws, span)) begin
              f = 8'd0; ws = now_i; bu = 32'd0;
            end
            if ({1'b0, f} + {1'b0, r} >= {1'b0, failure_limit_i}) begin
              status_o = ST_LIMIT;
            end else begin
              if (r != 8'hFF) r = r + 8'd1;
              granted_o = 1'b1;
            end
          end
        end
      end
      OP_QUERY: begin
        if (!hit_i.hit) begin
          if (sat_until_i <= now_i) granted_o = 1'b1;
          else status_o = ST_SATURATED;
        end else begin
          wr_en_o = 1'b1;
          if (bu > now_i) begin
            status_o = ST_LOCKED;
          end else begin
            if (elapsed_ge(now_i, ws, span)) begin
              f = 8'd0; ws = now_i;
            end
            if ({1'b0, f} + {1'b0, r} < {1'b0, failure_limit_i}) granted_o = 1'b1;
            else status_o = ST_LIMIT;
          end
        end
      end
      OP_FAIL: begin
        if (!hit_i.hit) begin
          if (full) begin
            sat_req  = 1'b1;
            status_o = ST_SATURATED;
          end else if (!hit_i.free_found) begin
            status_o = ST_SATURATED;
          end else begin
            create = 1'b1;
          end
        end
        if (hit_i.hit || create) begin
          wr_en_o = 1'b1;
          if (elapsed_ge(now_i, ws, span)) begin
            f = 8'd0; ws = now_i; bu = 32'd0;
          end
          if (f != 8'hFF) f = f + 8'd1;
          if (f >= failure_limit_i) bu = lock_end;
        end
      end
      OP_SUCCESS: begin
        if (!hit_i.hit) begin
          status_o = ST_NO_ENTRY;
        end else begin
          wr_en_o = 1'b1;
          if (r == 8'd0) begin
            wr_valid_o = 1'b0;
          end else begin
            f = 8'd0; bu = 32'd0; ws = now_i;
          end
        end
      end
      OP_FINISH_OK, OP_FINISH_FAIL, OP_FINISH_NEUT: begin
        if (!hit_i.hit) begin
          status_o = ST_NO_ENTRY;
        end else begin
          wr_en_o = 1'b1;
          if (r != 8'd0) r = r - 8'd1;
          if (op_i == OP_FINISH_OK) begin
            f = 8'd0; bu = 32'd0; ws = now_i;
          end else if (op_i == OP_FINISH_FAIL) begin
            if (elapsed_ge(now_i, ws, span)) begin
              f = 8'd0; ws = now_i; bu = 32'd0;
            end
            if (f != 8'hFF) f = f + 8'd1;
            if (f >= failure_limit_i) bu = lock_end;
          end
          if (r == 8'd0 && f == 8'd0 && bu <= now_i) wr_valid_o = 1'b0;
        end
      end
      default: begin
      end
    endcase

    wr_data_o.unknown   = unknown_i;
    wr_data_o.key_high  = unknown_i ? 64'd0 : key_high_i;
    wr_data_o.key_low   = unknown_i ? 64'd0 : key_low_i;
    wr_data_o.fail      = f;
    wr_data_o.resv      = r;
    wr_data_o.wstart    = ws;
    wr_data_o.blocked   = bu;
    wr_data_o.seen_at   = now_i;

    sat_we_o = sat_req && (lock_end > sat_until_i);
    sat_d_o  = lock_end;
    count_o  = count_i + CNT_W'(create) - CNT_W'(wr_en_o && !wr_valid_o);
  end

endmodule

// ===== rtl/per_source_login_rate_limiter.sv =====
// Top level: per-source login failure rate limiter with lockout.
// Result shows after the drop step, the lookup token walking the cell chain one
// cell per cycle, and the exec step. No new item is accepted until the previous
// result has been taken: in_ready is high only in the idle state.
// Reset: all entries invalid, saturation lockout cleared, registers at defaults.
module per_source_login_rate_limiter import lrl_pkg::*; #(
  parameter int unsigned SOURCE_ENTRIES = SourceEntriesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  operation_i,
  input  logic        address_known_i,
  input  logic [63:0] address_high_i,
  input  logic [63:0] address_low_i,
  input  logic [31:0] now_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        granted_o,
  output logic [2:0]  status_o,
  output logic [4:0]  tracked_sources_o
);

  localparam int unsigned N     = SOURCE_ENTRIES;
  localparam int unsigned IDX_W = (N > 1) ? $clog2(N) : 1;
  localparam int unsigned CNT_W = $clog2(N + 1);

  state_e state_q, state_d;

  logic [7:0]  failure_limit_q;
  logic [31:0] window_ticks_q, lockout_ticks_q, sat_until_q;
  logic [4:0]  source_limit_q;

  op_e         op_q;
  logic        unknown_q;
  logic [63:0] key_high_q, key_low_q;
  logic [31:0] now_q;

  logic [N-1:0] tok_q, tok_d;
  logic         granted_q;
  logic [2:0]   status_q;
  logic [31:0]  count32;
  logic [4:0]   tracked_q;

  hit_t             hit_w      [N];
  logic [IDX_W-1:0] hit_idx_w  [N];
  logic [IDX_W-1:0] free_idx_w [N];
  logic [CNT_W-1:0] count_w    [N];

  logic             drop;
  logic [32:0]      retention;
  logic             accept;
  logic             wr_en, wr_valid, sat_we, ex_granted;
  logic [IDX_W-1:0] wr_idx;
  data_t            wr_data;
  logic [31:0]      sat_d;
  status_e          ex_status;
  logic [CNT_W-1:0] ex_count;

  assign accept    = in_valid_i && in_ready_o;
  assign retention = {1'b0, window_ticks_q} + {1'b0, lockout_ticks_q};
  assign drop      = (state_q == S_DROP) &&
                     (op_q == OP_RESERVE || op_q == OP_QUERY ||
                      op_q == OP_FAIL || op_q == OP_COUNT);

  always_comb begin
    state_d = state_q;
    tok_d   = tok_q;
    case (state_q)
      S_IDLE: if (accept) state_d = S_DROP;
      S_DROP: begin
        state_d = S_SCAN;
        tok_d   = N'(1);
      end
      S_SCAN: begin
        tok_d = tok_q << 1;
        if (tok_q[N-1]) state_d = S_EXEC;
      end
      S_EXEC: state_d = S_OUT;
      S_OUT:  if (out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = (state_q == S_IDLE);
    out_valid_o = (state_q == S_OUT);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      tok_q           <= '0;
      sat_until_q     <= '0;
      failure_limit_q <= FailureLimitReset;
      window_ticks_q  <= WindowTicksReset;
      lockout_ticks_q <= LockoutTicksReset;
      source_limit_q  <= SourceLimitReset;
    end else begin
      state_q <= state_d;
      tok_q   <= tok_d;
      if (state_q == S_EXEC && sat_we) sat_until_q <= sat_d;
      if (cfg_we_i) begin
        case (cfg_e'(cfg_index_i))
          CFG_FAILURE_LIMIT: failure_limit_q <= cfg_data_i[7:0];
          CFG_WINDOW_TICKS:  window_ticks_q  <= cfg_data_i;
          CFG_LOCKOUT_TICKS: lockout_ticks_q <= cfg_data_i;
          CFG_SOURCE_LIMIT:  source_limit_q  <= cfg_data_i[4:0];
          default: ;
        endcase
      end
    end
  end

  assign count32 = 32'(ex_count);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q       <= op_e'(operation_i);
      unknown_q  <= !address_known_i;
      key_high_q <= address_high_i;
      key_low_q  <= address_low_i;
      now_q      <= now_i;
    end
    if (state_q == S_EXEC) begin
      granted_q <= ex_granted;
      status_q  <= ex_status;
      tracked_q <= count32[4:0];
    end
  end

  for (genvar g = 0; g < N; g++) begin : g_cell
    hit_t             p_hit;
    logic [IDX_W-1:0] p_hidx, p_fidx;
    logic [CNT_W-1:0] p_cnt;
    if (g == 0) begin : g_head
      assign p_hit  = '0;
      assign p_hidx = '0;
      assign p_fidx = '0;
      assign p_cnt  = '0;
    end else begin : g_link
      assign p_hit  = hit_w[g-1];
      assign p_hidx = hit_idx_w[g-1];
      assign p_fidx = free_idx_w[g-1];
      assign p_cnt  = count_w[g-1];
    end
    lrl_cell #(
      .IDX_W(IDX_W), .CNT_W(CNT_W), .CELL_IDX(g)
    ) u_cell (
      .clk_i, .rst_ni,
      .drop_i         (drop),
      .now_i          (now_q),
      .retention_i    (retention),
      .unknown_i      (unknown_q),
      .key_high_i     (key_high_q),
      .key_low_i      (key_low_q),
      .step_i         ((state_q == S_SCAN) && tok_q[g]),
      .prev_hit_i     (p_hit),
      .prev_hit_idx_i (p_hidx),
      .prev_free_idx_i(p_fidx),
      .prev_count_i   (p_cnt),
      .wr_en_i        ((state_q == S_EXEC) && wr_en && (wr_idx == IDX_W'(g))),
      .wr_valid_i     (wr_valid),
      .wr_data_i      (wr_data),
      .hit_o          (hit_w[g]),
      .hit_idx_o      (hit_idx_w[g]),
      .free_idx_o     (free_idx_w[g]),
      .count_o        (count_w[g])
    );
  end

  lrl_exec #(
    .SOURCE_ENTRIES(N), .IDX_W(IDX_W), .CNT_W(CNT_W)
  ) u_exec (
    .op_i           (op_q),
    .unknown_i      (unknown_q),
    .key_high_i     (key_high_q),
    .key_low_i      (key_low_q),
    .now_i          (now_q),
    .failure_limit_i(failure_limit_q),
    .window_ticks_i (window_ticks_q),
    .lockout_ticks_i(lockout_ticks_q),
    .source_limit_i (source_limit_q),
    .sat_until_i    (sat_until_q),
    .hit_i          (hit_w[N-1]),
    .hit_idx_i      (hit_idx_w[N-1]),
    .free_idx_i     (free_idx_w[N-1]),
    .count_i        (count_w[N-1]),
    .wr_en_o        (wr_en),
    .wr_idx_o       (wr_idx),
    .wr_valid_o     (wr_valid),
    .wr_data_o      (wr_data),
    .sat_we_o       (sat_we),
    .sat_d_o        (sat_d),
    .granted_o      (ex_granted),
    .status_o       (ex_status),
    .count_o        (ex_count)
  );

  assign granted_o         = granted_q;
  assign status_o          = status_q;
  assign tracked_sources_o = tracked_q;

endmodule

// ===== rtl/lrl_checker.sv =====
// Port-level checks for the login rate limiter, bound to the top level.
module lrl_checker import lrl_pkg::*; #(
  parameter int unsigned SOURCE_ENTRIES = SourceEntriesDefault
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        granted_o,
  input logic [2:0]  status_o,
  input logic [4:0]  tracked_sources_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result item dropped while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o && !out_valid_o)
    else $error("item accepted while another is in flight");

  a_grant_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && granted_o |-> status_o == ST_DONE)
    else $error("grant with non-done status");

  a_tracked_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> 32'(tracked_sources_o) <= SOURCE_ENTRIES ||
                    SOURCE_ENTRIES > 31)
    else $error("tracked source count beyond table size");

endmodule

bind per_source_login_rate_limiter lrl_checker #(.SOURCE_ENTRIES(SOURCE_ENTRIES)) u_lrl_checker (.*);
